// ===== rtl/gbr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gbr_pkg;

    // Pin vectors on the ports are a fixed 54 bits; storage spans up to 64 pin slots.
    localparam int PIN_FIELD_W = 54;
    localparam int SLOT_W      = 64;
    localparam int DATA_W      = 32;
    localparam int INDEX_W     = 6;

    // Function select layout: ten 3-bit fields per word, eight word slots in the read mux.
    localparam int MODE_W      = 3;
    localparam int PULL_W      = 2;
    localparam int FSEL_FIELDS = 10;
    localparam int FSEL_W      = FSEL_FIELDS * MODE_W;
    localparam int FSEL_GROUPS = 8;
    localparam int FLAT_W      = FSEL_GROUPS * FSEL_W;

    // Word offsets
    localparam logic [INDEX_W-1:0] W_FSEL_FIRST = 6'd0;
    localparam logic [INDEX_W-1:0] W_FSEL_LAST  = 6'd5;
    localparam logic [INDEX_W-1:0] W_SET_LO     = 6'd7;
    localparam logic [INDEX_W-1:0] W_SET_HI     = 6'd8;
    localparam logic [INDEX_W-1:0] W_CLR_LO     = 6'd10;
    localparam logic [INDEX_W-1:0] W_CLR_HI     = 6'd11;
    localparam logic [INDEX_W-1:0] W_LEV_LO     = 6'd13;
    localparam logic [INDEX_W-1:0] W_LEV_HI     = 6'd14;
    localparam logic [INDEX_W-1:0] W_PULL       = 6'd37;
    localparam logic [INDEX_W-1:0] W_PCLK_LO    = 6'd38;
    localparam logic [INDEX_W-1:0] W_PCLK_HI    = 6'd39;

    // Access kinds
    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    // Pin codes
    localparam logic [MODE_W-1:0] MODE_OUTPUT = 3'd1;
    localparam logic [PULL_W-1:0] PULL_DOWN   = 2'd1;
    localparam logic [PULL_W-1:0] PULL_UP     = 2'd2;

    typedef struct packed {
        logic       fsel_wr;
        logic       fsel_rd;
        logic       set_wr;
        logic       clr_wr;
        logic       lev_rd;
        logic       pull_wr;
        logic       pull_rd;
        logic       pclk_wr;
        logic       upper;
        logic [2:0] fsel_idx;
    } gbr_access_t;

endpackage

`default_nettype wire

// ===== rtl/gbr_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface gbr_req_if;
    logic                               valid;
    logic                               ready;
    logic                               action;
    logic [gbr_pkg::INDEX_W-1:0]        word_index;
    logic [gbr_pkg::DATA_W-1:0]         write_data;
    logic [gbr_pkg::PIN_FIELD_W-1:0]    pad_levels;

    modport source (output valid, action, word_index, write_data, pad_levels, input ready);
    modport sink   (input valid, action, word_index, write_data, pad_levels, output ready);
endinterface

interface gbr_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [gbr_pkg::DATA_W-1:0]         read_data;
    logic [gbr_pkg::PIN_FIELD_W-1:0]    drive_levels;
    logic [gbr_pkg::PIN_FIELD_W-1:0]    drive_enables;
    logic [gbr_pkg::PIN_FIELD_W-1:0]    pull_ups;
    logic [gbr_pkg::PIN_FIELD_W-1:0]    pull_downs;

    modport source (output valid, read_data, drive_levels, drive_enables, pull_ups, pull_downs,
                    input ready);
    modport sink   (input valid, read_data, drive_levels, drive_enables, pull_ups, pull_downs,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/gbr_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gbr_decode (
    input  logic                         enable,
    input  logic                         action,
    input  logic [gbr_pkg::INDEX_W-1:0]  word_index,
    output gbr_pkg::gbr_access_t         access
);
    import gbr_pkg::*;

    logic wr;
    logic rd;

    assign wr = enable && (action == ACT_WRITE);
    assign rd = (action == ACT_READ);

    always_comb
    begin
        access          = '0;
        access.fsel_idx = word_index[2:0];
        unique case (word_index) inside
            [W_FSEL_FIRST:W_FSEL_LAST]:
            begin
                access.fsel_wr = wr;
                access.fsel_rd = rd;
            end
            W_SET_LO, W_SET_HI:
            begin
                access.set_wr = wr;
                access.upper  = (word_index == W_SET_HI);
            end
            W_CLR_LO, W_CLR_HI:
            begin
                access.clr_wr = wr;
                access.upper  = (word_index == W_CLR_HI);
            end
            W_LEV_LO, W_LEV_HI:
            begin
                access.lev_rd = rd;
                access.upper  = (word_index == W_LEV_HI);
            end
            W_PULL:
            begin
                access.pull_wr = wr;
                access.pull_rd = rd;
            end
            W_PCLK_LO, W_PCLK_HI:
            begin
                access.pclk_wr = wr;
                access.upper   = (word_index == W_PCLK_HI);
            end
            default:
            begin
                // unmapped word: read zero, ignore write
                access.upper = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/gbr_pin_state.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gbr_pin_state #(
    parameter int PIN_COUNT = 54
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  gbr_pkg::gbr_access_t             access,
    input  logic [gbr_pkg::DATA_W-1:0]       write_data,
    input  logic [gbr_pkg::PIN_FIELD_W-1:0]  pad_levels,
    output logic [gbr_pkg::DATA_W-1:0]       read_data,
    output logic [gbr_pkg::PIN_FIELD_W-1:0]  drive_levels,
    output logic [gbr_pkg::PIN_FIELD_W-1:0]  drive_enables,
    output logic [gbr_pkg::PIN_FIELD_W-1:0]  pull_ups,
    output logic [gbr_pkg::PIN_FIELD_W-1:0]  pull_downs
);
    import gbr_pkg::*;

    logic [MODE_W-1:0]    mode_reg [PIN_COUNT];
    logic [PULL_W-1:0]    pull_reg [PIN_COUNT];
    logic [PIN_COUNT-1:0] latch_reg;
    logic [PIN_COUNT-1:0] latch_next;
    logic [PULL_W-1:0]    pull_ctl_reg;

    logic [SLOT_W-1:0]    spread;
    logic [PIN_COUNT-1:0] sel_pins;
    logic [PIN_COUNT-1:0] en_pins;
    logic [PIN_COUNT-1:0] up_pins;
    logic [PIN_COUNT-1:0] down_pins;
    logic [PIN_COUNT-1:0] pad_pins;
    logic [PIN_COUNT-1:0] lev_pins;
    logic [SLOT_W-1:0]    pad_ext;
    logic [SLOT_W-1:0]    lev_ext;
    logic [SLOT_W-1:0]    latch_ext;
    logic [SLOT_W-1:0]    en_ext;
    logic [SLOT_W-1:0]    up_ext;
    logic [SLOT_W-1:0]    down_ext;
    logic [FLAT_W-1:0]    modes_flat;
    logic [FSEL_W-1:0]    fsel_words [FSEL_GROUPS];

    // place the write word on the addressed half of the pin vector
    assign spread   = access.upper ? {write_data, DATA_W'(0)} : {DATA_W'(0), write_data};
    assign sel_pins = spread[PIN_COUNT-1:0];

    always_comb
    begin
        latch_next = latch_reg;
        if (access.set_wr)
        begin
            latch_next = latch_reg | sel_pins;
        end
        else if (access.clr_wr)
        begin
            latch_next = latch_reg & ~sel_pins;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_reg    <= '0;
            pull_ctl_reg <= '0;
        end
        else
        begin
            latch_reg <= latch_next;
            if (access.pull_wr)
            begin
                pull_ctl_reg <= write_data[PULL_W-1:0];
            end
        end
    end

    genvar p;
    generate
        for (p = 0; p < PIN_COUNT; p++)
        begin : g_pin
            localparam int GROUP = p / FSEL_FIELDS;
            localparam int SLOT  = p % FSEL_FIELDS;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    mode_reg[p] <= '0;
                end
                else if (access.fsel_wr && (access.fsel_idx == 3'(GROUP)))
                begin
                    mode_reg[p] <= write_data[SLOT*MODE_W +: MODE_W];
                end
            end

            // pull clock copies the current pull code into every selected pin
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    pull_reg[p] <= '0;
                end
                else if (access.pclk_wr && sel_pins[p])
                begin
                    pull_reg[p] <= pull_ctl_reg;
                end
            end

            assign en_pins[p]   = (mode_reg[p] == MODE_OUTPUT);
            assign up_pins[p]   = (pull_reg[p] == PULL_UP);
            assign down_pins[p] = (pull_reg[p] == PULL_DOWN);
            assign modes_flat[p*MODE_W +: MODE_W] = mode_reg[p];
        end
    endgenerate

    assign modes_flat[FLAT_W-1:PIN_COUNT*MODE_W] = '0;

    genvar g;
    generate
        for (g = 0; g < FSEL_GROUPS; g++)
        begin : g_fsel
            assign fsel_words[g] = modes_flat[g*FSEL_W +: FSEL_W];
        end
    endgenerate

    assign pad_ext   = SLOT_W'(pad_levels);
    assign pad_pins  = pad_ext[PIN_COUNT-1:0];
    assign lev_pins  = (latch_reg & en_pins) | (pad_pins & ~en_pins);
    assign lev_ext   = SLOT_W'(lev_pins);
    assign latch_ext = SLOT_W'(latch_reg);
    assign en_ext    = SLOT_W'(en_pins);
    assign up_ext    = SLOT_W'(up_pins);
    assign down_ext  = SLOT_W'(down_pins);

    always_comb
    begin
        read_data = '0;
        if (access.fsel_rd)
        begin
            read_data = DATA_W'(fsel_words[access.fsel_idx]);
        end
        else if (access.lev_rd)
        begin
            read_data = access.upper ? lev_ext[SLOT_W-1:DATA_W] : lev_ext[DATA_W-1:0];
        end
        else if (access.pull_rd)
        begin
            read_data = DATA_W'(pull_ctl_reg);
        end
    end

    assign drive_levels  = latch_ext[PIN_FIELD_W-1:0];
    assign drive_enables = en_ext[PIN_FIELD_W-1:0];
    assign pull_ups      = up_ext[PIN_FIELD_W-1:0];
    assign pull_downs    = down_ext[PIN_FIELD_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/gpio_bank_registers.sv =====
// Result: each accepted access yields its result item on rsp in the next cycle.
// Throughput: one access per cycle; a new item is taken in the same cycle the
// previous result leaves, so the rate is set only by rsp.ready.
// Reset: rst_n clears all pin modes to input, the output latch, the pull
// control word and every pin pull state, and empties the result register.
`timescale 1ns / 1ps
`default_nettype none

module gpio_bank_registers #(
    parameter int PIN_COUNT = 54
) (
    input  logic       clk,
    input  logic       rst_n,
    gbr_req_if.sink    req,
    gbr_rsp_if.source  rsp
);
    import gbr_pkg::*;

    logic                    accept;
    logic                    in_ready;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [DATA_W-1:0]       read_data_reg;
    logic [DATA_W-1:0]       read_data_comb;
    gbr_access_t             access;

    // Take a new item whenever the result register is empty or draining this
    // cycle; an access with a stalled result waits at the input.
    assign in_ready  = !out_valid_reg || rsp.ready;
    assign req.ready = in_ready;
    assign accept    = req.valid && in_ready;

    // Decode the word offset; write strobes are gated by accept so the pin
    // state only moves on an accepted item.
    gbr_decode u_decode (
        .enable     (accept),
        .action     (req.action),
        .word_index (req.word_index),
        .access     (access)
    );

    // Pin state: modes, latch, pull control and per-pin pulls. Its vector
    // outputs reflect the registered state, which advances only at an accept,
    // the same edge at which the result register loads. So while a result is
    // held, they show the state after that result's access.
    gbr_pin_state #(
        .PIN_COUNT (PIN_COUNT)
    ) u_pin_state (
        .clk           (clk),
        .rst_n         (rst_n),
        .access        (access),
        .write_data    (req.write_data),
        .pad_levels    (req.pad_levels),
        .read_data     (read_data_comb),
        .drive_levels  (rsp.drive_levels),
        .drive_enables (rsp.drive_enables),
        .pull_ups      (rsp.pull_ups),
        .pull_downs    (rsp.pull_downs)
    );

    // Hold the result until it is taken; reload on every accept.
    assign out_valid_next = accept || (out_valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Read data is zero for writes; decode leaves read selects low then.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_data_reg <= read_data_comb;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = read_data_reg;

endmodule

`default_nettype wire

// ===== rtl/gbr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gbr_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic                             in_action,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic [gbr_pkg::DATA_W-1:0]       out_read_data,
    input  logic [gbr_pkg::PIN_FIELD_W-1:0]  out_drive_levels,
    input  logic [gbr_pkg::PIN_FIELD_W-1:0]  out_pull_ups,
    input  logic [gbr_pkg::PIN_FIELD_W-1:0]  out_pull_downs
);
    import gbr_pkg::*;

    logic in_fire;

    assign in_fire = in_valid && in_ready;

    // every accepted access yields a result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid)
        else $error("accepted access produced no result");

    // write accesses return zero read data
    a_write_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (in_action == ACT_WRITE)) |=> (out_read_data == '0))
        else $error("write access returned nonzero read data");

    // latch only moves on an accepted access
    a_latch_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> $stable(out_drive_levels))
        else $error("output latch changed without an access");

    // a pin never shows pull-up and pull-down at once
    a_pull_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (out_pull_ups & out_pull_downs) == '0)
        else $error("pin reports both pull-up and pull-down");

    // stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");

endmodule

bind gpio_bank_registers gbr_checker u_gbr_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (req.valid),
    .in_ready         (req.ready),
    .in_action        (req.action),
    .out_valid        (rsp.valid),
    .out_ready        (rsp.ready),
    .out_read_data    (rsp.read_data),
    .out_drive_levels (rsp.drive_levels),
    .out_pull_ups     (rsp.pull_ups),
    .out_pull_downs   (rsp.pull_downs)
);

`default_nettype wire
